[hw/rtl/nps_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the nearest point search core.
// Used by nps_ctrl, nps_datapath and nearest_point_search_core; no dependencies.
package nps_pkg;

  localparam int CRD_W  = 24;  // Q12.12 coordinate
  localparam int TAG_W  = 16;  // Q1.15 surface tag
  localparam int IDX_W  = 10;  // entry index field
  localparam int CFG_W  = 11;  // points_in_use register
  localparam int MAG_W  = 25;  // magnitude of a coordinate difference
  localparam int DST_W  = 50;  // squared distance and its sum over three axes
  localparam int ROOT_W = 26;  // min_distance field

  localparam logic [DST_W-1:0] ROOT_BIT_INIT = DST_W'(1) << (DST_W - 2);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_POINTS_IN_USE = 1'b0;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [TAG_W-1:0]        u;
    logic [TAG_W-1:0]        v;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic issue;
    logic sqrt_start;
    logic fetch;
    logic load;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic pipe_busy;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/nps_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the nearest point search core: accepts transactions and steps
// the datapath through scan, drain, square root and result load. Uses nps_pkg.
module nps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          kind_i,
  output logic          in_stall_o,
  input  nps_pkg::stat_t stat_i,
  output nps_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   empty_q, empty_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.wr         = accept && (kind_i == nps_pkg::KIND_WRITE);
    cmd_o.start      = accept && (kind_i == nps_pkg::KIND_QUERY);
    cmd_o.issue      = (state_q == ST_SCAN);
    cmd_o.sqrt_start = (state_q == ST_DRAIN) && !stat_i.pipe_busy;
    cmd_o.fetch      = (state_q == ST_ROOT) && stat_i.sqrt_done;
    cmd_o.load       = (state_q == ST_LOAD) && stat_i.out_free;
    cmd_o.load_empty = empty_q;
  end

  always_comb begin
    state_d = state_q;
    empty_d = empty_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == nps_pkg::KIND_QUERY)) begin
          if (stat_i.count_zero) begin
            state_d = ST_LOAD;
            empty_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
            empty_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (stat_i.sqrt_done) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      empty_q <= empty_d;
    end
  end

endmodule

[hw/rtl/nps_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the nearest point search core: entry memory, distance pipeline,
// running minimum, iterative square root and result register. Uses nps_pkg.
module nps_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nps_pkg::cmd_t                    cmd_i,
  output nps_pkg::stat_t                   stat_o,
  input  logic [nps_pkg::CFG_W-1:0]        points_in_use_i,
  input  logic [nps_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [nps_pkg::CRD_W-1:0] coord_x_i,
  input  logic signed [nps_pkg::CRD_W-1:0] coord_y_i,
  input  logic signed [nps_pkg::CRD_W-1:0] coord_z_i,
  input  logic [nps_pkg::TAG_W-1:0]        param_u_i,
  input  logic [nps_pkg::TAG_W-1:0]        param_v_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             valid_res_o,
  output logic [nps_pkg::IDX_W-1:0]        best_index_o,
  output logic signed [nps_pkg::CRD_W-1:0] near_x_o,
  output logic signed [nps_pkg::CRD_W-1:0] near_y_o,
  output logic signed [nps_pkg::CRD_W-1:0] near_z_o,
  output logic [nps_pkg::TAG_W-1:0]        near_u_o,
  output logic [nps_pkg::TAG_W-1:0]        near_v_o,
  output logic [nps_pkg::ROOT_W-1:0]       min_distance_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = (AW + 1 > nps_pkg::CFG_W) ? AW + 1 : nps_pkg::CFG_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  nps_pkg::entry_t mem [TABLE_DEPTH];
  nps_pkg::entry_t rd_data_q;
  nps_pkg::entry_t wr_entry;

  logic signed [nps_pkg::CRD_W-1:0] qx_q, qy_q, qz_q;
  logic [CW-1:0] cnt_q, limit;
  logic [CW-1:0] wr_idx_ext;
  logic [AW-1:0] rd_addr;

  logic                  s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [AW-1:0]         s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [nps_pkg::MAG_W-1:0] mx_d, my_d, mz_d, mx_q, my_q, mz_q;
  logic [nps_pkg::DST_W-1:0] sx_q, sy_q, sz_q, sum_q;

  logic                      have_q;
  logic [nps_pkg::DST_W-1:0] best_d_q;
  logic [AW-1:0]             best_idx_q;
  logic [CW-1:0]             best_idx_ext;

  logic [nps_pkg::DST_W-1:0] rem_q, root_q, bit_q;
  logic [nps_pkg::DST_W:0]   trial;

  logic out_valid_q;

  function automatic logic [nps_pkg::MAG_W-1:0] abs_diff(
    input logic signed [nps_pkg::CRD_W-1:0] a,
    input logic signed [nps_pkg::CRD_W-1:0] b
  );
    logic [nps_pkg::MAG_W-1:0] d;
    d = {a[nps_pkg::CRD_W-1], a} - {b[nps_pkg::CRD_W-1], b};
    return d[nps_pkg::MAG_W-1] ? (~d + nps_pkg::MAG_W'(1)) : d;
  endfunction

  assign wr_idx_ext = CW'(entry_index_i);
  assign limit = (CW'(points_in_use_i) > DEPTH_C) ? DEPTH_C : CW'(points_in_use_i);
  assign rd_addr = cmd_i.fetch ? best_idx_q : cnt_q[AW-1:0];
  assign best_idx_ext = CW'(best_idx_q);

  assign wr_entry.x = coord_x_i;
  assign wr_entry.y = coord_y_i;
  assign wr_entry.z = coord_z_i;
  assign wr_entry.u = param_u_i;
  assign wr_entry.v = param_v_i;

  assign stat_o.count_zero = (points_in_use_i == '0);
  assign stat_o.last_issue = (cnt_q == limit - CW'(1));
  assign stat_o.pipe_busy  = s1_v_q || s2_v_q || s3_v_q || s4_v_q;
  assign stat_o.sqrt_done  = (bit_q == '0);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (wr_idx_ext < DEPTH_C)) begin
      mem[wr_idx_ext[AW-1:0]] <= wr_entry;
    end
    if (cmd_i.issue || cmd_i.fetch) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    mx_d = abs_diff(qx_q, rd_data_q.x);
    my_d = abs_diff(qy_q, rd_data_q.y);
    mz_d = abs_diff(qz_q, rd_data_q.z);
    trial = {1'b0, root_q} + {1'b0, bit_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      have_q <= 1'b0;
      bit_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (cmd_i.start) begin
        have_q <= 1'b0;
      end else if (s4_v_q) begin
        have_q <= 1'b1;
      end
      if (cmd_i.sqrt_start) begin
        bit_q <= nps_pkg::ROOT_BIT_INIT;
      end else if (bit_q != '0) begin
        bit_q <= bit_q >> 2;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
      qz_q <= coord_z_i;
    end
    s1_idx_q <= cnt_q[AW-1:0];
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    s4_idx_q <= s3_idx_q;
    mx_q <= mx_d;
    my_q <= my_d;
    mz_q <= mz_d;
    sx_q <= mx_q * mx_q;
    sy_q <= my_q * my_q;
    sz_q <= mz_q * mz_q;
    sum_q <= sx_q + sy_q + sz_q;
    if (s4_v_q && (!have_q || (sum_q < best_d_q))) begin
      best_d_q   <= sum_q;
      best_idx_q <= s4_idx_q;
    end
    if (cmd_i.sqrt_start) begin
      rem_q  <= best_d_q;
      root_q <= '0;
    end else if (bit_q != '0) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[nps_pkg::DST_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
    end
    if (cmd_i.load) begin
      valid_res_o    <= !cmd_i.load_empty;
      best_index_o   <= cmd_i.load_empty ? '0 : best_idx_ext[nps_pkg::IDX_W-1:0];
      near_x_o       <= cmd_i.load_empty ? '0 : rd_data_q.x;
      near_y_o       <= cmd_i.load_empty ? '0 : rd_data_q.y;
      near_z_o       <= cmd_i.load_empty ? '0 : rd_data_q.z;
      near_u_o       <= cmd_i.load_empty ? '0 : rd_data_q.u;
      near_v_o       <= cmd_i.load_empty ? '0 : rd_data_q.v;
      min_distance_o <= cmd_i.load_empty ? '0 : root_q[nps_pkg::ROOT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  a_root_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_q != '0) |-> !(s1_v_q || s2_v_q || s3_v_q || s4_v_q))
    else $error("square root running while distance pipeline busy");

  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (best_idx_ext < DEPTH_C))
    else $error("best index beyond table depth");

  a_load_after_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && !cmd_i.load_empty) |-> (bit_q == '0))
    else $error("result loaded before square root finished");

endmodule

[hw/rtl/nearest_point_search_core.sv]
`timescale 1ns / 1ps
// Nearest point search core: a table of TABLE_DEPTH tagged 3D points is
// written one entry per write transaction; a query transaction scans entries
// 0 to points_in_use-1 (capped at the depth) one per cycle through a four
// stage distance pipeline, keeps the first strict minimum, then takes the
// square root of the winning squared distance bit by bit. The result sits
// in an output register, and input is stalled while a query runs.
// Depends on nps_pkg, nps_ctrl and nps_datapath.
module nearest_point_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [nps_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [nps_pkg::CRD_W-1:0] coord_x_i,
  input  logic signed [nps_pkg::CRD_W-1:0] coord_y_i,
  input  logic signed [nps_pkg::CRD_W-1:0] coord_z_i,
  input  logic [nps_pkg::TAG_W-1:0]        param_u_i,
  input  logic [nps_pkg::TAG_W-1:0]        param_v_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             valid_res_o,
  output logic [nps_pkg::IDX_W-1:0]        best_index_o,
  output logic signed [nps_pkg::CRD_W-1:0] near_x_o,
  output logic signed [nps_pkg::CRD_W-1:0] near_y_o,
  output logic signed [nps_pkg::CRD_W-1:0] near_z_o,
  output logic [nps_pkg::TAG_W-1:0]        near_u_o,
  output logic [nps_pkg::TAG_W-1:0]        near_v_o,
  output logic [nps_pkg::ROOT_W-1:0]       min_distance_o
);

  logic [nps_pkg::CFG_W-1:0] points_q;
  logic                      reg_sel;
  nps_pkg::cmd_t             cmd;
  nps_pkg::stat_t            stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == nps_pkg::REG_POINTS_IN_USE);
  assign prdata  = reg_sel ? 32'(points_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      points_q <= pwdata[nps_pkg::CFG_W-1:0];
    end
  end

  nps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nps_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .points_in_use_i (points_q),
    .entry_index_i   (entry_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .param_u_i       (param_u_i),
    .param_v_i       (param_v_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .valid_res_o     (valid_res_o),
    .best_index_o    (best_index_o),
    .near_x_o        (near_x_o),
    .near_y_o        (near_y_o),
    .near_z_o        (near_z_o),
    .near_u_o        (near_u_o),
    .near_v_o        (near_v_o),
    .min_distance_o  (min_distance_o)
  );

endmodule
